@@ rtl/fbpa_pkg.sv @@
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

   localparam int CHUNK_PORT_W  = 4;
   localparam int BLOCK_W       = 8;
   localparam int BSIZE_W       = 16;
   localparam int OFFSET_W      = 24;
   localparam int STATUS_W      = 2;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int PICK_CHUNK_W  = 8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCKS_PER_CHUNK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_SIZE       = 1'b1;

   localparam logic [BLOCK_W-1:0]  RESET_BLOCKS_PER_CHUNK = 8'd255;
   localparam logic [BSIZE_W-1:0]  RESET_BLOCK_SIZE       = 16'd8;

   // per-chunk bookkeeping word
   typedef struct packed {
      logic [BLOCK_W-1:0] first_free;
      logic [BLOCK_W-1:0] free_count;
      logic [BLOCK_W-1:0] mark;
   } chunk_word_type;

   // chunk choice for an allocate
   typedef struct packed {
      logic                    found;
      logic                    fresh;
      logic [PICK_CHUNK_W-1:0] chunk;
   } pick_type;

endpackage

@@ rtl/fbpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/fbpa_pick.sv @@
// Chunk selection for an allocate: cached chunk, lowest active chunk with room, or a new chunk.
module fbpa_pick import fbpa_pkg::*; #(
   parameter int MAX_CHUNKS = 16,
   localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
   localparam int AW = $clog2(MAX_CHUNKS + 1)
) (
   input  logic [MAX_CHUNKS-1:0] nonempty,
   input  logic [AW-1:0]         active,
   input  logic [CW-1:0]         cached,
   input  logic                  cached_valid,
   output pick_type              pick
);

   logic                    hit;
   logic                    any;
   logic [PICK_CHUNK_W-1:0] low;

   assign hit = cached_valid && (9'(cached) < 9'(active)) && nonempty[cached];

   always_comb begin
      any = 1'b0;
      low = '0;
      for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
         if (nonempty[i] && (9'(i) < 9'(active))) begin
            any = 1'b1;
            low = PICK_CHUNK_W'(i);
         end
      end
   end

   always_comb begin
      pick = '0;
      if (hit) begin
         pick.found = 1'b1;
         pick.chunk = PICK_CHUNK_W'(cached);
      end else if (any) begin
         pick.found = 1'b1;
         pick.chunk = low;
      end else if (9'(active) < 9'(MAX_CHUNKS)) begin
         pick.found = 1'b1;
         pick.fresh = 1'b1;
         pick.chunk = PICK_CHUNK_W'(active);
      end
   end

endmodule

@@ rtl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: top level with chunk table and next-index memories.
// rsp_valid is loaded from ST_CHK for a free, an out-of-memory answer or an allocate from a chunk's
// untouched blocks, and from ST_LINK after ST_CHK for an allocate that reuses a freed block (one
// extra read of the next-index memory). One word at a time: busy is high until the result is
// registered, so a new word is taken only once the last result is in the output register.
// Sync reset clears chunk count, room flags, cache and config (255 blocks, 8 bytes).
// Memories are not cleared; results are shown for one cycle and cannot be stalled.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int MAX_CHUNKS = 16,
   parameter int MAX_BLOCKS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_cmd,
   input  logic [CHUNK_PORT_W-1:0] req_free_chunk,
   input  logic [BLOCK_W-1:0]      req_free_block,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [CHUNK_PORT_W-1:0] rsp_got_chunk,
   output logic [BLOCK_W-1:0]      rsp_got_block,
   output logic [OFFSET_W-1:0]     rsp_byte_offset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CW          = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int AW          = $clog2(MAX_CHUNKS + 1);
   localparam int BW          = $clog2(MAX_BLOCKS);
   localparam int STORE_DEPTH = MAX_CHUNKS << BW;
   localparam int SAW         = $clog2(STORE_DEPTH);
   localparam int CWORD_W     = $bits(chunk_word_type);

   typedef enum logic [1:0] {ST_IDLE, ST_CHK, ST_LINK} state_type;

   function automatic logic [BLOCK_W-1:0] blk_mod(input logic [BLOCK_W-1:0] b);
      logic [16:0] r;
      r = 17'(b);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (17'(MAX_BLOCKS) << k)) begin
            r = r - (17'(MAX_BLOCKS) << k);
         end
      end
      return r[BLOCK_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic                  cmd_ff, cmd_in;
   logic [CW-1:0]         chunk_ff, chunk_in;
   logic [BLOCK_W-1:0]    fb_ff, fb_in;
   logic                  bad_ff, bad_in;
   logic                  fresh_ff, fresh_in;
   chunk_word_type        cw_ff, cw_in;
   logic [MAX_CHUNKS-1:0] nonempty_ff, nonempty_in;
   logic [AW-1:0]         active_ff, active_in;
   logic [CW-1:0]         cached_ff, cached_in;
   logic                  cached_valid_ff, cached_valid_in;
   logic [BLOCK_W-1:0]    bpc_ff, bpc_in;
   logic [BSIZE_W-1:0]    bsize_ff, bsize_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [CHUNK_PORT_W-1:0] rsp_chunk_ff, rsp_chunk_in;
   logic [BLOCK_W-1:0]    rsp_block_ff, rsp_block_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;

   logic                  accept;
   pick_type              pick;
   logic [8:0]            nb;
   chunk_word_type        cw_rd;
   chunk_word_type        cw_chk;
   chunk_word_type        cur;
   logic [BLOCK_W-1:0]    next_idx;
   logic [BLOCK_W-1:0]    cnt_dec;
   logic [BLOCK_W-1:0]    cnt_inc;
   logic [OFFSET_W-1:0]   prod;
   logic [BLOCK_W-1:0]    fb_mod;
   logic [BLOCK_W-1:0]    head_mod;

   logic                  crd_en;
   logic [CW-1:0]         crd_addr;
   logic [CWORD_W-1:0]    crd_data;
   logic                  cwr_en;
   chunk_word_type        cwr_data;
   logic                  srd_en;
   logic [SAW-1:0]        srd_addr;
   logic [BLOCK_W-1:0]    srd_data;
   logic                  swr_en;
   logic [SAW-1:0]        swr_addr;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      nb = (bpc_ff == '0) ? 9'd1 : 9'(bpc_ff);
      if (nb > 9'(MAX_BLOCKS)) begin
         nb = 9'(MAX_BLOCKS);
      end
   end

   fbpa_pick #(.MAX_CHUNKS(MAX_CHUNKS)) u_pick (
      .nonempty     (nonempty_ff),
      .active       (active_ff),
      .cached       (cached_ff),
      .cached_valid (cached_valid_ff),
      .pick         (pick)
   );

   fbpa_ram #(.WIDTH(CWORD_W), .DEPTH(MAX_CHUNKS)) u_chunk_ram (
      .clock   (clock),
      .wr_en   (cwr_en),
      .wr_addr (chunk_ff),
      .wr_data (CWORD_W'(cwr_data)),
      .rd_en   (crd_en),
      .rd_addr (crd_addr),
      .rd_data (crd_data)
   );

   fbpa_ram #(.WIDTH(BLOCK_W), .DEPTH(STORE_DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (swr_en),
      .wr_addr (swr_addr),
      .wr_data (cw_chk.first_free),
      .rd_en   (srd_en),
      .rd_addr (srd_addr),
      .rd_data (srd_data)
   );

   assign cw_rd = chunk_word_type'(crd_data);

   always_comb begin
      if (fresh_ff) begin
         cw_chk            = '0;
         cw_chk.free_count = nb[BLOCK_W-1:0];
      end else begin
         cw_chk = cw_rd;
      end
   end

   assign cur      = (state_ff == ST_LINK) ? cw_ff : cw_chk;
   assign next_idx = cur.first_free + 8'd1;
   assign cnt_dec  = cur.free_count - 8'd1;
   assign cnt_inc  = cur.free_count + 8'd1;
   assign prod     = OFFSET_W'(cur.first_free) * OFFSET_W'(bsize_ff);

   assign crd_en   = accept;
   assign crd_addr = (req_cmd == CMD_FREE) ? CW'(req_free_chunk) : CW'(pick.chunk);
   assign fb_mod   = blk_mod(fb_ff);
   assign head_mod = blk_mod(cw_chk.first_free);
   assign swr_addr = SAW'({chunk_ff, fb_mod[BW-1:0]});
   assign srd_addr = SAW'({chunk_ff, head_mod[BW-1:0]});

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      chunk_in        = chunk_ff;
      fb_in           = fb_ff;
      bad_in          = bad_ff;
      fresh_in        = fresh_ff;
      cw_in           = cw_ff;
      nonempty_in     = nonempty_ff;
      active_in       = active_ff;
      cached_in       = cached_ff;
      cached_valid_in = cached_valid_ff;
      bpc_in          = bpc_ff;
      bsize_in        = bsize_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_chunk_in    = '0;
      rsp_block_in    = '0;
      rsp_offset_in   = '0;
      cwr_en          = 1'b0;
      cwr_data        = cur;
      swr_en          = 1'b0;
      srd_en          = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_BLOCKS_PER_CHUNK: bpc_in = csr_data[BLOCK_W-1:0];
            REG_BLOCK_SIZE:       bsize_in = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHK;
               cmd_in   = req_cmd;
               fb_in    = req_free_block;
               chunk_in = crd_addr;
               if (req_cmd == CMD_FREE) begin
                  bad_in   = (9'(req_free_chunk) >= 9'(active_ff));
                  fresh_in = 1'b0;
               end else begin
                  bad_in   = !pick.found;
                  fresh_in = pick.fresh;
               end
            end
         end
         ST_CHK: begin
            cw_in = cw_chk;
            if (cmd_ff == CMD_FREE) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (bad_ff || (9'(fb_ff) >= nb) || (9'(cw_chk.free_count) >= nb) ||
                   (fb_ff >= cw_chk.mark)) begin
                  rsp_status_in = STATUS_BAD;
               end else begin
                  swr_en                = 1'b1;
                  cwr_en                = 1'b1;
                  cwr_data.first_free   = fb_ff;
                  cwr_data.free_count   = cnt_inc;
                  nonempty_in[chunk_ff] = (cnt_inc != '0);
               end
            end else if (bad_ff) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OOM;
            end else begin
               cached_in       = chunk_ff;
               cached_valid_in = 1'b1;
               if (fresh_ff) begin
                  active_in = active_ff + AW'(1);
               end
               if (cw_chk.first_free >= cw_chk.mark) begin
                  state_in              = ST_IDLE;
                  cwr_en                = 1'b1;
                  cwr_data.first_free   = next_idx;
                  cwr_data.free_count   = cnt_dec;
                  cwr_data.mark         = next_idx;
                  nonempty_in[chunk_ff] = (cnt_dec != '0);
                  rsp_valid_in          = 1'b1;
                  rsp_chunk_in          = CHUNK_PORT_W'(chunk_ff);
                  rsp_block_in          = cur.first_free;
                  rsp_offset_in         = prod;
               end else begin
                  state_in = ST_LINK;
                  srd_en   = 1'b1;
               end
            end
         end
         ST_LINK: begin
            state_in              = ST_IDLE;
            cwr_en                = 1'b1;
            cwr_data.first_free   = srd_data;
            cwr_data.free_count   = cnt_dec;
            nonempty_in[chunk_ff] = (cnt_dec != '0);
            rsp_valid_in          = 1'b1;
            rsp_chunk_in          = CHUNK_PORT_W'(chunk_ff);
            rsp_block_in          = cur.first_free;
            rsp_offset_in         = prod;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         nonempty_ff     <= '0;
         active_ff       <= '0;
         cached_valid_ff <= 1'b0;
         bpc_ff          <= RESET_BLOCKS_PER_CHUNK;
         bsize_ff        <= RESET_BLOCK_SIZE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         nonempty_ff     <= nonempty_in;
         active_ff       <= active_in;
         cached_valid_ff <= cached_valid_in;
         bpc_ff          <= bpc_in;
         bsize_ff        <= bsize_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      chunk_ff      <= chunk_in;
      fb_ff         <= fb_in;
      bad_ff        <= bad_in;
      fresh_ff      <= fresh_in;
      cw_ff         <= cw_in;
      cached_ff     <= cached_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chunk_ff  <= rsp_chunk_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_got_chunk   = rsp_chunk_ff;
   assign rsp_got_block   = rsp_block_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a word is still in work");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_got_chunk == '0) && (rsp_got_block == '0) && (rsp_byte_offset == '0))
      else $error("error result carries a handle");

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      9'(active_ff) <= 9'(MAX_CHUNKS))
      else $error("active chunk count beyond pool size");

endmodule

@@ test/fbpa_checker.sv @@
`timescale 1ns / 100ps
// Pool allocator checker: predicts every answer word and compares it with the block's output.
module fbpa_checker import fbpa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_cmd,
   input  logic [CHUNK_PORT_W-1:0] req_free_chunk,
   input  logic [BLOCK_W-1:0]      req_free_block,
   input  logic                    rsp_valid,
   input  logic [STATUS_W-1:0]     rsp_status,
   input  logic [CHUNK_PORT_W-1:0] rsp_got_chunk,
   input  logic [BLOCK_W-1:0]      rsp_got_block,
   input  logic [OFFSET_W-1:0]     rsp_byte_offset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output int                      errors,
   output int                      outstanding,
   output int                      requests,
   output int                      grants,
   output int                      oom_answers,
   output int                      refusals
);

   localparam int POOL_CHUNKS = 16;
   localparam int POOL_BLOCKS = 256;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [CHUNK_PORT_W-1:0] chunk;
      logic [BLOCK_W-1:0]      block;
      logic [OFFSET_W-1:0]     offset;
   } answer_type;

   answer_type awaited[$];
   answer_type fresh;
   answer_type oldest;

   logic [BLOCK_W-1:0] next_idx [POOL_CHUNKS][POOL_BLOCKS];
   logic [BLOCK_W-1:0] head_of  [POOL_CHUNKS];
   logic [BLOCK_W-1:0] room     [POOL_CHUNKS];
   logic [BLOCK_W-1:0] mark     [POOL_CHUNKS];
   int                 active_n;
   int                 cache_chunk;
   bit                 cache_ok;
   logic [BLOCK_W-1:0] blocks_cfg;
   logic [BSIZE_W-1:0] size_cfg;

   task automatic apply_request(input logic cmd, input logic [CHUNK_PORT_W-1:0] fc,
                                input logic [BLOCK_W-1:0] fb, output answer_type ans);
      logic [8:0]         nb;
      int                 c;
      int                 i;
      bit                 found;
      logic [BLOCK_W-1:0] head;
      logic [BLOCK_W-1:0] nxt;
      nb = (blocks_cfg == 0) ? 9'd1 : {1'b0, blocks_cfg};
      ans = '0;
      if (cmd == CMD_FREE) begin
         if (fc >= active_n || fb >= nb || room[fc] >= nb || fb >= mark[fc]) begin
            ans.status = STATUS_BAD;
         end else begin
            next_idx[fc][fb] = head_of[fc];
            head_of[fc] = fb;
            room[fc] = room[fc] + 8'd1;
         end
      end else begin
         found = 1'b0;
         c = 0;
         if (cache_ok && cache_chunk < active_n && room[cache_chunk] > 0) begin
            c = cache_chunk;
            found = 1'b1;
         end else begin
            for (i = 0; i < active_n; i++) begin
               if (!found && room[i] > 0) begin
                  c = i;
                  found = 1'b1;
               end
            end
            if (!found && active_n < POOL_CHUNKS) begin
               c = active_n;
               head_of[c] = '0;
               room[c] = nb[7:0];
               mark[c] = '0;
               active_n++;
               found = 1'b1;
            end
         end
         if (!found) begin
            ans.status = STATUS_OOM;
         end else begin
            cache_chunk = c;
            cache_ok = 1'b1;
            head = head_of[c];
            if (head >= mark[c]) begin
               nxt = head + 8'd1;
               mark[c] = nxt;
            end else begin
               nxt = next_idx[c][head];
            end
            head_of[c] = nxt;
            room[c] = room[c] - 8'd1;
            ans.status = STATUS_OK;
            ans.chunk  = c[CHUNK_PORT_W-1:0];
            ans.block  = head;
            ans.offset = OFFSET_W'(head) * OFFSET_W'(size_cfg);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (next_idx[c, b]) next_idx[c][b] = '0;
         foreach (head_of[c]) begin
            head_of[c] = '0;
            room[c] = '0;
            mark[c] = '0;
         end
         active_n = 0;
         cache_chunk = 0;
         cache_ok = 0;
         blocks_cfg = RESET_BLOCKS_PER_CHUNK;
         size_cfg = RESET_BLOCK_SIZE;
         awaited.delete();
         errors = 0;
         requests = 0;
         grants = 0;
         oom_answers = 0;
         refusals = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               errors++;
               $error("answer word with nothing awaited");
            end else begin
               oldest = awaited.pop_front();
               if (rsp_status !== oldest.status) begin
                  errors++;
                  $error("status expected %0d got %0d", oldest.status, rsp_status);
               end
               if (rsp_got_chunk !== oldest.chunk) begin
                  errors++;
                  $error("got_chunk expected %0d got %0d", oldest.chunk, rsp_got_chunk);
               end
               if (rsp_got_block !== oldest.block) begin
                  errors++;
                  $error("got_block expected %0d got %0d", oldest.block, rsp_got_block);
               end
               if (rsp_byte_offset !== oldest.offset) begin
                  errors++;
                  $error("byte_offset expected %0d got %0d", oldest.offset, rsp_byte_offset);
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == REG_BLOCKS_PER_CHUNK) blocks_cfg = csr_data[BLOCK_W-1:0];
            else if (csr_index == REG_BLOCK_SIZE) size_cfg = csr_data;
         end
         if (start && !busy) begin
            apply_request(req_cmd, req_free_chunk, req_free_block, fresh);
            awaited = {awaited, fresh};
            requests++;
            if (fresh.status == STATUS_OOM) oom_answers++;
            else if (fresh.status == STATUS_BAD) refusals++;
            else if (req_cmd == CMD_ALLOC) grants++;
         end
      end
      outstanding = awaited.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives the allocator with directed and random words and gives the verdict.
module tb;
   import fbpa_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [CHUNK_PORT_W-1:0] chunk;
      logic [BLOCK_W-1:0]      block;
   } handle_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_cmd = CMD_ALLOC;
   logic [CHUNK_PORT_W-1:0] req_free_chunk = '0;
   logic [BLOCK_W-1:0]      req_free_block = '0;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [CHUNK_PORT_W-1:0] rsp_got_chunk;
   logic [BLOCK_W-1:0]      rsp_got_block;
   logic [OFFSET_W-1:0]     rsp_byte_offset;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = REG_BLOCKS_PER_CHUNK;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   int errors, outstanding, requests, grants, oom_answers, refusals;
   int stall = 0;
   int last_size;

   logic       issued_cmds[$];
   handle_type live[$];
   handle_type got_handle;

   always #2 clock = ~clock;

   fixed_block_pool_allocator dut (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_free_chunk, .req_free_block,
      .rsp_valid, .rsp_status, .rsp_got_chunk, .rsp_got_block, .rsp_byte_offset,
      .csr_wr_en, .csr_index, .csr_data
   );

   fbpa_checker u_check (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_free_chunk, .req_free_block,
      .rsp_valid, .rsp_status, .rsp_got_chunk, .rsp_got_block, .rsp_byte_offset,
      .csr_wr_en, .csr_index, .csr_data,
      .errors, .outstanding, .requests, .grants, .oom_answers, .refusals
   );

   // granted handles feed later frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && issued_cmds.size() != 0) begin
         if (issued_cmds.pop_front() == CMD_ALLOC && rsp_status == STATUS_OK) begin
            got_handle.chunk = rsp_got_chunk;
            got_handle.block = rsp_got_block;
            live = {live, got_handle};
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
         $display("fixed_block_pool_allocator verification failed");
         $finish;
      end
   end

   task automatic issue_word(input logic cmd, input logic [CHUNK_PORT_W-1:0] fc,
                             input logic [BLOCK_W-1:0] fb, input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_free_chunk = fc;
      req_free_block = fb;
      issued_cmds = {issued_cmds, cmd};
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic alloc_word(input int idle_pct);
      issue_word(CMD_ALLOC, CHUNK_PORT_W'($urandom), BLOCK_W'($urandom), idle_pct);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // upper byte of the block count write is junk
   task automatic set_pool(input logic [BLOCK_W-1:0] nblocks, input logic [BSIZE_W-1:0] bsize);
      write_reg(REG_BLOCKS_PER_CHUNK, {8'($urandom), nblocks});
      write_reg(REG_BLOCK_SIZE, bsize);
   endtask

   task automatic random_mix(input int n, input int alloc_pct, input int free_pct,
                             input int idle_pct);
      int         roll;
      int         j;
      handle_type h;
      repeat (n) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) begin
            alloc_word(idle_pct);
         end else if (roll < alloc_pct + free_pct && live.size() != 0) begin
            j = $urandom_range(0, live.size() - 1);
            h = live[j];
            // an occasional handle is kept, so it may be freed twice
            if ($urandom_range(0, 15) != 0) live.delete(j);
            issue_word(CMD_FREE, h.chunk, h.block, idle_pct);
         end else begin
            issue_word(CMD_FREE, CHUNK_PORT_W'($urandom),
                       $urandom_range(0, 1) ? BLOCK_W'($urandom) : BLOCK_W'($urandom_range(0, 7)),
                       idle_pct);
         end
      end
   endtask

   initial begin
      logic [BSIZE_W-1:0] odd_size;
      int                 tries;
      odd_size = BSIZE_W'($urandom_range(2, 65534));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_pool(8'd3, 16'd65535);
      issue_word(CMD_FREE, 4'd0, 8'd0, 24);
      repeat (4) alloc_word(24);
      issue_word(CMD_FREE, 4'd0, 8'd3, 24);
      issue_word(CMD_FREE, 4'd0, 8'd255, 24);
      issue_word(CMD_FREE, 4'd15, 8'd0, 24);
      issue_word(CMD_FREE, 4'd1, 8'd2, 24);
      issue_word(CMD_FREE, 4'd0, 8'd1, 24);
      issue_word(CMD_FREE, 4'd0, 8'd2, 24);
      alloc_word(24);
      issue_word(CMD_FREE, 4'd1, 8'd0, 24);
      issue_word(CMD_FREE, 4'd1, 8'd1, 24);
      issue_word(CMD_FREE, 4'd1, 8'd1, 24);
      alloc_word(24);
      issue_word(CMD_FREE, 4'd1, 8'd1, 24);
      issue_word(CMD_FREE, 4'd0, 8'd1, 24);
      alloc_word(24);
      alloc_word(24);
      drain();

      set_pool(8'd255, 16'd65535);
      random_mix(450, 85, 10, 24);
      drain();

      // zero block count acts as one; fill the pool until it runs dry
      set_pool(8'd0, 16'd1);
      last_size = oom_answers;
      tries = 0;
      while (oom_answers == last_size && tries < 400) begin
         alloc_word(53);
         tries++;
      end
      random_mix(300, 70, 25, 53);
      drain();

      set_pool(8'd200, odd_size);
      random_mix(420, 50, 40, 0);
      drain();
      repeat (10) @(posedge clock);

      $display("%0d words checked: %0d grants, %0d out-of-memory, %0d refused",
               requests, grants, oom_answers, refusals);
      $display("block counts 3, 255, 0 and 200 with block sizes 65535, 1 and %0d", odd_size);
      if (errors == 0) $display("fixed_block_pool_allocator verification clean");
      else $display("fixed_block_pool_allocator verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_pick.sv
rtl/fixed_block_pool_allocator.sv
test/fbpa_checker.sv
test/tb.sv
